// File: sv/dvkm_pkg.sv
`default_nettype none

package dvkm_pkg;

    // Register file geometry.
    localparam int REG_COUNT      = 16;
    localparam int REG_ADDR_W     = 4;
    localparam int DATA_W         = 8;
    localparam int MAX_COLUMNS    = 8;
    localparam int MATRIX_COLUMNS = 8;

    // Port widths.
    localparam int FUNC_W   = 3;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // Access kinds carried on the slave tuser.
    localparam logic [FUNC_W-1:0] FUNC_READ_A  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_B  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_KEY     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TIMER   = 3'd5;

    // Register indexes and flag bits.
    localparam logic [REG_ADDR_W-1:0] IFR_INDEX        = 4'hD;
    localparam logic [REG_ADDR_W-1:0] T1_LOW_INDEX     = 4'h4;
    localparam logic [REG_ADDR_W-1:0] PORT_A_SHAKE     = 4'h1;
    localparam logic [REG_ADDR_W-1:0] PORT_A_PLAIN     = 4'hF;
    localparam logic [REG_ADDR_W-1:0] COL_SELECT_INDEX = 4'h0;
    localparam int                    T1_FLAG_BIT      = 6;
    localparam logic [DATA_W-1:0]     ALL_ONES         = 8'hFF;

    // One decoded access or event.
    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [REG_ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0]     wdata;
        logic [ROW_W-1:0]      key_row;
        logic [COL_W-1:0]      key_col;
        logic                  key_down;
    } access_t;

    // Power-up contents of an adapter register: port registers idle high.
    function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_ADDR_W-1:0] idx);
        logic [DATA_W-1:0] val;
        val = '0;
        if (idx == 4'h0 || idx == 4'h1) begin
            val = ALL_ONES;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// File: sv/dvkm_in_stage.sv
`default_nettype none

module dvkm_in_stage (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // s_tdata: reg_addr[3:0], wdata[11:4], key_row[14:12], key_col[17:15],
    //          key_down[18], zero fill[23:19]
    input  wire logic [dvkm_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: func[2:0]
    input  wire logic [dvkm_pkg::FUNC_W-1:0]   s_tuser,
    input  wire logic                     step_ready_i,
    output logic                          item_valid_o,
    output dvkm_pkg::access_t             item_o
);
    import dvkm_pkg::*;

    logic    valid_reg;
    access_t item_reg;
    access_t item_next;

    // The stage takes a new word when empty or when its word moves on.
    assign s_tready = !valid_reg || step_ready_i;

    // Unpack the slave word.
    always_comb begin
        item_next.func     = s_tuser;
        item_next.reg_addr = s_tdata[3:0];
        item_next.wdata    = s_tdata[11:4];
        item_next.key_row  = s_tdata[14:12];
        item_next.key_col  = s_tdata[17:15];
        item_next.key_down = s_tdata[18];
    end

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload holds until the next accepted word.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid_o = valid_reg;
    assign item_o       = item_reg;

endmodule

`default_nettype wire

// File: sv/dvkm_regs.sv
`default_nettype none

module dvkm_regs #(
    parameter int MATRIX_COLUMNS = dvkm_pkg::MATRIX_COLUMNS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step_en_i,
    input  wire dvkm_pkg::access_t         item_i,
    output logic [dvkm_pkg::DATA_W-1:0]    rdata_o
);
    import dvkm_pkg::*;

    logic [DATA_W-1:0] a_regs_reg   [REG_COUNT];
    logic [DATA_W-1:0] b_regs_reg   [REG_COUNT];
    logic [DATA_W-1:0] key_cols_reg [MATRIX_COLUMNS];
    logic [DATA_W-1:0] scan;
    logic [DATA_W-1:0] col_select;

    // Adapter A: plain byte writes, timer flag set by a fire and cleared by
    // a read of the timer low byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                a_regs_reg[i] <= reg_reset_value(REG_ADDR_W'(i));
            end
        end else if (step_en_i) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                if (item_i.func == FUNC_WRITE_A && item_i.reg_addr == REG_ADDR_W'(i)) begin
                    a_regs_reg[i] <= item_i.wdata;
                end
            end
            if (item_i.func == FUNC_TIMER) begin
                a_regs_reg[IFR_INDEX][T1_FLAG_BIT] <= 1'b1;
            end
            if (item_i.func == FUNC_READ_A && item_i.reg_addr == T1_LOW_INDEX) begin
                a_regs_reg[IFR_INDEX][T1_FLAG_BIT] <= 1'b0;
            end
        end
    end

    // Adapter B: plain byte writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                b_regs_reg[i] <= reg_reset_value(REG_ADDR_W'(i));
            end
        end else if (step_en_i) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                if (item_i.func == FUNC_WRITE_B && item_i.reg_addr == REG_ADDR_W'(i)) begin
                    b_regs_reg[i] <= item_i.wdata;
                end
            end
        end
    end

    // Key matrix: a low bit marks a held key; events on absent columns match nothing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MATRIX_COLUMNS; c++) begin
                key_cols_reg[c] <= ALL_ONES;
            end
        end else if (step_en_i && item_i.func == FUNC_KEY) begin
            for (int c = 0; c < MATRIX_COLUMNS; c++) begin
                if (item_i.key_col == COL_W'(c)) begin
                    key_cols_reg[c][item_i.key_row] <= !item_i.key_down;
                end
            end
        end
    end

    // Matrix scan: AND of every column driven low in B register 0.
    assign col_select = b_regs_reg[COL_SELECT_INDEX];

    always_comb begin
        scan = ALL_ONES;
        for (int c = 0; c < MATRIX_COLUMNS; c++) begin
            if (!col_select[c]) begin
                scan = scan & key_cols_reg[c];
            end
        end
    end

    // Read data from the state before this access updates it.
    always_comb begin
        case (item_i.func)
            FUNC_READ_A: begin
                rdata_o = a_regs_reg[item_i.reg_addr];
            end
            FUNC_READ_B: begin
                if (item_i.reg_addr == PORT_A_SHAKE || item_i.reg_addr == PORT_A_PLAIN) begin
                    rdata_o = scan;
                end else begin
                    rdata_o = b_regs_reg[item_i.reg_addr];
                end
            end
            default: begin
                rdata_o = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_timer_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en_i && item_i.func == FUNC_TIMER |=> a_regs_reg[IFR_INDEX][T1_FLAG_BIT])
        else $error("timer fire did not set the interrupt flag");

    a_t1_read_clears_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en_i && item_i.func == FUNC_READ_A && item_i.reg_addr == T1_LOW_INDEX
        |=> !a_regs_reg[IFR_INDEX][T1_FLAG_BIT])
        else $error("timer low read did not clear the interrupt flag");

    a_select_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_en_i && item_i.func == FUNC_WRITE_B) |=> $stable(b_regs_reg[COL_SELECT_INDEX]))
        else $error("column select changed without a write to adapter B");
`endif

endmodule

`default_nettype wire

// File: sv/dual_via_keyboard_matrix.sv
`default_nettype none

// Two 16-byte interface adapter register files and an active-low key matrix
// behind one stream port. Each slave word is one access or event, chosen by
// tuser: read or write on adapter A or B, a key press or release, or a timer
// fire that sets bit 6 of A register 13 (a read of A register 4 clears it).
// Reads of B registers 1 and 15 return the AND of the matrix columns driven
// low in B register 0. Every accepted word yields exactly one master word,
// zero for anything but a read. One word is taken per clock while the
// result is not stalled. Each accepted word passes through an input
// register, a single pass of register-file and scan logic, and a result
// register. A stalled result holds a full input register and s_tready low.
module dual_via_keyboard_matrix #(
    parameter int MATRIX_COLUMNS = dvkm_pkg::MATRIX_COLUMNS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: reg_addr[3:0], wdata[11:4], key_row[14:12], key_col[17:15],
    //          key_down[18], zero fill[23:19]
    input  wire logic [dvkm_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: func[2:0]
    input  wire logic [dvkm_pkg::FUNC_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: rdata[7:0]
    output logic [dvkm_pkg::M_DATA_W-1:0]          m_tdata
);
    import dvkm_pkg::*;

    logic              in_valid;
    access_t           item;
    logic              out_ready;
    logic              step_en;
    logic [DATA_W-1:0] rdata;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;

    // The result register frees when empty or when its word is taken.
    assign out_ready = !m_tvalid_reg || m_tready;
    assign step_en   = in_valid && out_ready;

    dvkm_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .step_ready_i (out_ready),
        .item_valid_o (in_valid),
        .item_o       (item)
    );

    dvkm_regs #(
        .MATRIX_COLUMNS (MATRIX_COLUMNS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en_i (step_en),
        .item_i    (item),
        .rdata_o   (rdata)
    );

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= in_valid;
        end
    end

    // Result data.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_tdata_reg <= rdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_tvalid)
        else $error("processed word produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !step_en)
        else $error("pending result overwritten");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && !out_ready |-> !s_tready)
        else $error("input stage accepted a word while stalled");
`endif

endmodule

`default_nettype wire
